[rtl/socc_pkg.sv]
// Shared types and constants for the segmented ones-complement checksum core.
// Used by every module under rtl/; depends on nothing else.
`default_nettype none

package socc_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 2048;

    localparam int SIZE_W  = 12;   // segment_size register width
    localparam int CNT_W   = 11;   // segment counter width
    localparam int QDEPTH  = 4;    // front-to-back queue depth
    localparam int QAW     = 2;    // queue address width

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHOLE    = 1'b1;

    localparam logic [7:0]  PAD_LOW    = 8'hFF;   // fills an odd final byte
    localparam logic [15:0] CHK_RESET  = 16'h0000;

    // Configuration seen by the front end
    typedef struct packed {
        logic [SIZE_W-1:0] seg_size;
        logic              whole;
    } t_cfg;

    // One classified byte, front to back
    typedef struct packed {
        logic [15:0] word;      // word to add when add is set
        logic        add;
        logic        close;     // this byte closes the segment
        logic        last;      // this byte closes the packet
        logic [15:0] expected;
    } t_item;

    // One result transaction
    typedef struct packed {
        logic [15:0]      chk;
        logic             ok;
        logic             last;
        logic [CNT_W-1:0] good;
        logic [CNT_W-1:0] total;
        logic             dropped;
    } t_result;

endpackage

`default_nettype wire

[rtl/socc_front.sv]
// Front end: accepts payload bytes, pairs them into words and finds segment ends.
// Depends on socc_pkg.
`default_nettype none

module socc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  socc_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_byte,
    input  logic [15:0]        i_expected,
    input  logic               i_last,
    input  logic               i_full,
    output logic               o_push,
    output socc_pkg::t_item    o_item
);
    import socc_pkg::*;

    logic              r_phase,   n_phase;
    logic [7:0]        r_pending, n_pending;
    logic [SIZE_W-1:0] r_cnt,     n_cnt;

    logic [SIZE_W:0] eff_raw;
    logic [SIZE_W:0] eff;
    logic [SIZE_W:0] cnt_inc;
    logic            close;

    assign o_ready = ~i_full;
    assign o_push  = i_valid & ~i_full;

    // Even segment length, at least two bytes
    always_comb begin
        eff_raw = {1'b0, i_cfg.seg_size} + {{SIZE_W{1'b0}}, 1'b1};
        eff     = {eff_raw[SIZE_W:1], 1'b0};
        if (eff < (SIZE_W+1)'(2)) begin
            eff = (SIZE_W+1)'(2);
        end
        cnt_inc = {1'b0, r_cnt} + {{SIZE_W{1'b0}}, 1'b1};
        close   = i_last | (~i_cfg.whole & (cnt_inc >= eff));
    end

    // At most one word per byte: a completed pair, or a padded high byte at close
    always_comb begin
        o_item.word     = r_phase ? {r_pending, i_byte} : {i_byte, PAD_LOW};
        o_item.add      = r_phase | close;
        o_item.close    = close;
        o_item.last     = i_last;
        o_item.expected = i_expected;
    end

    always_comb begin
        n_phase   = r_phase;
        n_pending = r_pending;
        n_cnt     = r_cnt;
        if (o_push) begin
            n_phase   = close ? 1'b0 : ~r_phase;
            n_pending = r_phase ? r_pending : i_byte;
            n_cnt     = (i_cfg.whole | close) ? '0 : cnt_inc[SIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= 1'b0;
            r_pending <= '0;
            r_cnt     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_cnt     <= n_cnt;
        end
    end

endmodule

`default_nettype wire

[rtl/socc_queue.sv]
// Short queue of classified bytes between the front and back ends.
// Depends on socc_pkg.
`default_nettype none

module socc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  socc_pkg::t_item  i_item,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output socc_pkg::t_item  o_head
);
    import socc_pkg::*;

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, n_wp;
    logic [QAW-1:0] r_rp, n_rp;
    logic [QAW:0]   r_count, n_count;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rp];

    always_comb begin
        n_wp    = i_push ? r_wp + 1'b1 : r_wp;
        n_rp    = i_pop  ? r_rp + 1'b1 : r_rp;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW+1)'(QDEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0 && r_count != (QAW+1)'(QDEPTH)) |-> r_wp != r_rp)
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

[rtl/socc_back.sv]
// Back end: end-around-carry accumulation, segment verdicts, packet counters,
// and the result register. Depends on socc_pkg.
`default_nettype none

module socc_back #(
    parameter int MAX_PACKET_BYTES = socc_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  socc_pkg::t_item   i_item,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output socc_pkg::t_result o_result
);
    import socc_pkg::*;

    localparam int CountLimitI = (MAX_PACKET_BYTES / 2 < 2047) ? MAX_PACKET_BYTES / 2 : 2047;
    localparam logic [CNT_W-1:0] CountLimit = CNT_W'(CountLimitI);

    logic [15:0]      r_sum,   n_sum;
    logic [CNT_W-1:0] r_good,  n_good;
    logic [CNT_W-1:0] r_total, n_total;
    logic             r_out_valid, n_out_valid;
    t_result          r_out,   n_out;

    logic [16:0]      s17;
    logic [15:0]      sum_now;
    logic [15:0]      chk;
    logic             ok;
    logic [CNT_W-1:0] good_inc;
    logic [CNT_W-1:0] total_inc;
    logic             out_free;

    assign out_free    = ~r_out_valid | i_out_ready;
    assign o_pop       = i_valid & (~i_item.close | out_free);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        s17     = {1'b0, r_sum} + {1'b0, i_item.word};
        sum_now = r_sum;
        if (i_item.add) begin
            sum_now = s17[16] ? s17[15:0] + 16'd1 : s17[15:0];
        end
        chk       = ~sum_now;
        ok        = (chk == i_item.expected);
        total_inc = (r_total < CountLimit) ? r_total + 1'b1 : r_total;
        good_inc  = (ok && r_good < CountLimit) ? r_good + 1'b1 : r_good;
    end

    always_comb begin
        n_sum       = r_sum;
        n_good      = r_good;
        n_total     = r_total;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~i_out_ready;
        if (o_pop) begin
            if (i_item.close) begin
                n_sum         = CHK_RESET;
                n_good        = i_item.last ? '0 : good_inc;
                n_total       = i_item.last ? '0 : total_inc;
                n_out_valid   = 1'b1;
                n_out.chk     = chk;
                n_out.ok      = ok;
                n_out.last    = i_item.last;
                n_out.good    = i_item.last ? good_inc  : '0;
                n_out.total   = i_item.last ? total_inc : '0;
                n_out.dropped = i_item.last & (good_inc == '0);
            end else begin
                n_sum = sum_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= CHK_RESET;
            r_good      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sum       <= n_sum;
            r_good      <= n_good;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    a_good_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_good <= r_total)
        else $error("good segment count above total");

    a_drop_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.dropped == (r_out.last && r_out.good == '0)))
        else $error("drop flag inconsistent with good count");

    a_mid_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last) |-> (r_out.good == '0 && r_out.total == '0))
        else $error("counts shown on a mid-packet segment");

endmodule

`default_nettype wire

[rtl/segmented_ones_complement_checksum_core.sv]
// Segmented ones-complement checksum checker, top level.
// Path: a closing byte's transaction is written into the queue, then popped into the result
//   register that drives o_m_tvalid, once it reaches the queue head and the result register is free.
// Throughput: one payload byte per cycle while the queue has room (single back-end accumulate step).
// Reset (i_rst_n low, synchronous): sums, counters, queue and result valid cleared;
//   segment_size returns to 32 and whole_packet_mode to 0.
// Depends on socc_pkg, socc_front, socc_queue, socc_back.
`default_nettype none

module segmented_ones_complement_checksum_core #(
    parameter int MAX_PACKET_BYTES = socc_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [socc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [socc_pkg::SIZE_W-1:0]     i_cfg_data,
    // payload byte stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [23:0]                     i_s_tdata,   // [7:0] data_byte, [23:8] expected_checksum
    input  logic                            i_s_tlast,   // last_of_packet
    // segment result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [39:0]                     o_m_tdata,   // [15:0] segment_checksum, [16] segment_ok,
                                                         // [27:17] good_segments,
                                                         // [38:28] total_segments, [39] packet_dropped
    output logic                            o_m_tlast    // end_of_packet
);
    import socc_pkg::*;

    // Configuration registers; the user must write them only while the core is idle (not enforced here)
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seg_size <= SIZE_W'(32);
            r_cfg.whole    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SEG_SIZE: r_cfg.seg_size <= i_cfg_data;
                CFG_WHOLE:    r_cfg.whole    <= i_cfg_data[0];
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    // Front end: pairing and segment boundary detection
    logic    q_full;
    logic    q_push;
    t_item   q_in;
    logic    q_valid;
    logic    q_pop;
    t_item   q_head;
    t_result res;

    socc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_byte     (i_s_tdata[7:0]),
        .i_expected (i_s_tdata[23:8]),
        .i_last     (i_s_tlast),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_item     (q_in)
    );

    // Queue decouples byte intake from result back-pressure
    socc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // Back end: accumulate, judge, count, hold the result
    socc_back #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_result    (res)
    );

    assign o_m_tdata = {res.dropped, res.total, res.good, res.ok, res.chk};
    assign o_m_tlast = res.last;

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for segmented_ones_complement_checksum_core: a directed table, then random
// payload and register traffic, checked against an in-bench segment checksum predictor.
// Depends on socc_pkg and the core RTL under rtl/.

module tb;
    import socc_pkg::*;

    localparam int PKT_BYTES     = MAX_PACKET_BYTES_DEF;
    localparam int COUNT_CAP     = (PKT_BYTES / 2 < 2047) ? PKT_BYTES / 2 : 2047;
    localparam int RANDOM_BYTES  = 1400;    // normal random payload before stopping
    localparam int SETTLE_CYCLES = 12;      // queue and result register drain, with margin
    localparam int HOLD_CYCLES   = 400;     // long receiver hold-off
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PRINT_CAP     = 40;
    localparam int N_ROWS        = 25;

    // ------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_SEG_SIZE;
    logic [SIZE_W-1:0]    i_cfg_data  = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [23:0]          i_s_tdata   = '0;    // [7:0] data_byte, [23:8] expected_checksum
    logic                 i_s_tlast   = 1'b0;  // last_of_packet
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [39:0]          o_m_tdata;           // [15:0] checksum, [16] ok, [27:17] good,
                                               // [38:28] total, [39] dropped
    logic                 o_m_tlast;           // end_of_packet

    segmented_ones_complement_checksum_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Checksum predictor: register copies and per-packet state, at reset values
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] size_reg    = 12'd32;
    logic              whole_reg   = 1'b0;
    logic [15:0]       sum_acc     = '0;     // folded 16-bit running sum
    logic [7:0]        high_byte   = '0;     // first byte of a half-built word
    logic              high_held   = 1'b0;   // 1: a high byte waits for its partner
    logic [SIZE_W-1:0] seg_fill    = '0;     // bytes already in the open segment
    int                good_tally  = 0;
    int                total_tally = 0;

    t_result expected_segments [$];          // predicted results, oldest first
    int      mismatches    = 0;
    int      results_seen  = 0;

    // end-around carry add
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // checksum the open segment would carry if byte d closed it now
    function automatic logic [15:0] closing_sum(input logic [7:0] d);
        logic [15:0] s;
        if (high_held) s = ones_add(sum_acc, {high_byte, d});
        else           s = ones_add(sum_acc, {d, PAD_LOW});
        return ~s;
    endfunction

    // fold one accepted byte into the state; closed says whether a result comes out
    function automatic void accumulate_byte(input logic [7:0] d, input logic [15:0] cks,
                                            input logic last, output bit closed,
                                            output t_result r);
        int          span;
        logic [15:0] chk;
        r    = '0;
        span = (int'(size_reg) + 1) & ~1;
        if (span < 2) span = 2;            // sizes 0 and 1 behave as 2

        if (!high_held) begin
            high_byte = d;
            high_held = 1'b1;
        end else begin
            sum_acc   = ones_add(sum_acc, {high_byte, d});
            high_held = 1'b0;
        end

        if (whole_reg) begin
            seg_fill = '0;
            closed   = last;
        end else begin
            // a shrunk size closes on the first byte at or past the new span
            closed   = last || (int'(seg_fill) + 1 >= span);
            seg_fill = seg_fill + 1'b1;
        end
        if (!closed) return;

        // odd final byte: pad the low half with ones
        if (high_held) sum_acc = ones_add(sum_acc, {high_byte, PAD_LOW});
        chk = ~sum_acc;
        if (total_tally < COUNT_CAP) total_tally++;
        if (chk == cks && good_tally < COUNT_CAP) good_tally++;

        r.chk     = chk;
        r.ok      = (chk == cks);
        r.last    = last;
        r.good    = last ? CNT_W'(good_tally) : '0;
        r.total   = last ? CNT_W'(total_tally) : '0;
        r.dropped = last && good_tally == 0;

        sum_acc   = '0;
        high_byte = '0;
        high_held = 1'b0;
        seg_fill  = '0;
        if (last) begin
            good_tally  = 0;
            total_tally = 0;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("ERROR t=%0t result %0d: %s got %0h want %0h",
                     $time, results_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Result monitor: every accepted transaction against the oldest prediction
    // ------------------------------------------------------------------
    t_result seen_res;
    t_result want_res;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen_res.chk     = o_m_tdata[15:0];
            seen_res.ok      = o_m_tdata[16];
            seen_res.good    = o_m_tdata[27:17];
            seen_res.total   = o_m_tdata[38:28];
            seen_res.dropped = o_m_tdata[39];
            seen_res.last    = o_m_tlast;
            if (expected_segments.size() == 0) begin
                report_mismatch("result with nothing pending", seen_res.chk, 0);
            end else begin
                want_res = expected_segments.pop_front();
                if (seen_res.chk != want_res.chk)
                    report_mismatch("segment_checksum", seen_res.chk, want_res.chk);
                if (seen_res.ok != want_res.ok)
                    report_mismatch("segment_ok", seen_res.ok, want_res.ok);
                if (seen_res.last != want_res.last)
                    report_mismatch("end_of_packet", seen_res.last, want_res.last);
                if (seen_res.good != want_res.good)
                    report_mismatch("good_segments", seen_res.good, want_res.good);
                if (seen_res.total != want_res.total)
                    report_mismatch("total_segments", seen_res.total, want_res.total);
                if (seen_res.dropped != want_res.dropped)
                    report_mismatch("packet_dropped", seen_res.dropped, want_res.dropped);
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: own stall pattern, plus a long hold-off on request
    // ------------------------------------------------------------------
    int hold_asks = 0;     // bumped by the stimulus side
    int hold_seen = 0;
    int hold_left = 0;
    int rx_run    = 0;
    int rx_mode   = 0;

    always @(posedge i_clk) begin
        if (hold_seen != hold_asks) begin
            hold_seen  <= hold_asks;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            if (rx_run == 0) begin
                rx_mode <= $urandom_range(0, 3);
                rx_run  <= $urandom_range(20, 200);
            end else begin
                rx_run  <= rx_run - 1;
            end
            case (rx_mode)
                0:       i_m_tready <= 1'b1;                         // no stalls
                1:       i_m_tready <= 1'($urandom_range(0, 1));     // coin flip
                2:       i_m_tready <= (rx_run % 5) != 0;            // periodic stall
                default: i_m_tready <= ($urandom_range(0, 7) == 0);  // mostly stalled
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    int cycle_count = 0;

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TIMEOUT after %0d cycles, %0d results pending",
                 cycle_count, expected_segments.size());
        $display("segmented_ones_complement_checksum_core: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------
    int bytes_sent = 0;
    int burst_left = 0;
    bit gaps_on    = 1'b1;

    // offer one byte transaction, hold it until accepted, then predict.
    // match: replace cks with the checksum this byte would close the segment on.
    // Leaves tvalid high; the caller decides whether a gap follows.
    task automatic send_byte(input logic [7:0] d, input logic [15:0] cks, input logic last,
                             input bit match, output bit closed, output t_result r);
        if (match) cks = closing_sum(d);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {cks, d};
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        accumulate_byte(d, cks, last, closed, r);
    endtask

    task automatic offer(input logic [7:0] d, input logic [15:0] cks, input logic last,
                         input bit match);
        bit      closed;
        t_result r;
        send_byte(d, cks, last, match, closed, r);
        if (closed) expected_segments.push_back(r);
        bytes_sent++;
    endtask

    // bursts of random length, random gaps between them
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 24);
        if (gaps_on) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // finish = 0 leaves the packet open for the next call (possibly after a register change)
    task automatic send_packet(input int len, input int good_pct, input bit finish);
        logic [7:0] d;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
                0:       d = 8'h00;
                1:       d = 8'hFF;
                default: d = 8'($urandom);
            endcase
            offer(d, 16'($urandom), finish && i == len - 1, $urandom_range(0, 99) < good_pct);
            pace();
        end
    endtask

    // stop sending, wait for every predicted result, then let trailing bytes drain
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_segments.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only called with the block idle
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SEG_SIZE) size_reg = val;
        else                     whole_reg = val[0];
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Directed table. Pinned rows carry a result readable by hand; the rest
    // go through the predictor. idx is unused on byte rows.
    // ------------------------------------------------------------------
    typedef struct packed {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [SIZE_W-1:0]    value;
        logic [7:0]           d;
        logic [15:0]          cks;
        bit                   last;
        bit                   match;
        bit                   pin;
        logic [15:0]          p_chk;
        bit                   p_ok;
        logic [CNT_W-1:0]     p_good;
        logic [CNT_W-1:0]     p_total;
        bit                   p_drop;
    } t_step_row;

    t_step_row directed [N_ROWS] = '{
        // lone zero byte, padded to 0x00FF
        '{0, CFG_SEG_SIZE, 0, 8'h00, 16'hFF00, 1, 0, 1, 16'hFF00, 1, 1, 1, 0},
        // lone 0xFF, padded to all ones: checksum zero
        '{0, CFG_SEG_SIZE, 0, 8'hFF, 16'h0000, 1, 0, 1, 16'h0000, 1, 1, 1, 0},
        // wrong stored checksum: no good segment, packet dropped
        '{0, CFG_SEG_SIZE, 0, 8'hFF, 16'h1234, 0, 0, 0, 16'h0000, 0, 0, 0, 0},
        '{0, CFG_SEG_SIZE, 0, 8'hFF, 16'h1234, 1, 0, 1, 16'h0000, 0, 0, 1, 1},
        // 0xFFFF + 0x0001 wraps the carry around to 0x0001
        '{0, CFG_SEG_SIZE, 0, 8'hFF, 16'h0000, 0, 0, 0, 16'h0000, 0, 0, 0, 0},
        '{0, CFG_SEG_SIZE, 0, 8'hFF, 16'h0000, 0, 0, 0, 16'h0000, 0, 0, 0, 0},
        '{0, CFG_SEG_SIZE, 0, 8'h00, 16'h0000, 0, 0, 0, 16'h0000, 0, 0, 0, 0},
        '{0, CFG_SEG_SIZE, 0, 8'h01, 16'hFFFE, 1, 0, 1, 16'hFFFE, 1, 1, 1, 0},
        // all-zero words, checksum 0xFFFF
        '{0, CFG_SEG_SIZE, 0, 8'h00, 16'h0000, 0, 0, 0, 16'h0000, 0, 0, 0, 0},
        '{0, CFG_SEG_SIZE, 0, 8'h00, 16'hFFFF, 1, 0, 1, 16'hFFFF, 1, 1, 1, 0},
        // size 0 acts as 2; second segment is an odd tail
        '{1, CFG_SEG_SIZE, 0, 8'h00, 16'h0000, 0, 0, 0, 16'h0000, 0, 0, 0, 0},
        '{0, CFG_SEG_SIZE, 0, 8'hAB, 16'h0000, 0, 0, 0, 16'h0000, 0, 0, 0, 0},
        '{0, CFG_SEG_SIZE, 0, 8'hCD, 16'h0000, 0, 1, 0, 16'h0000, 0, 0, 0, 0},
        '{0, CFG_SEG_SIZE, 0, 8'hEF, 16'hFFFF, 1, 0, 0, 16'h0000, 0, 0, 0, 0},
        // whole-packet mode: one odd-length segment
        '{1, CFG_WHOLE,    1, 8'h00, 16'h0000, 0, 0, 0, 16'h0000, 0, 0, 0, 0},
        '{0, CFG_SEG_SIZE, 0, 8'h12, 16'h0000, 0, 0, 0, 16'h0000, 0, 0, 0, 0},
        '{0, CFG_SEG_SIZE, 0, 8'h34, 16'h0000, 0, 0, 0, 16'h0000, 0, 0, 0, 0},
        '{0, CFG_SEG_SIZE, 0, 8'h56, 16'h0000, 1, 1, 0, 16'h0000, 0, 0, 0, 0},
        // odd size 3 rounds up to 4, then a one-byte tail with a bad checksum
        '{1, CFG_WHOLE,    0, 8'h00, 16'h0000, 0, 0, 0, 16'h0000, 0, 0, 0, 0},
        '{1, CFG_SEG_SIZE, 3, 8'h00, 16'h0000, 0, 0, 0, 16'h0000, 0, 0, 0, 0},
        '{0, CFG_SEG_SIZE, 0, 8'h80, 16'h0000, 0, 0, 0, 16'h0000, 0, 0, 0, 0},
        '{0, CFG_SEG_SIZE, 0, 8'h01, 16'h0000, 0, 0, 0, 16'h0000, 0, 0, 0, 0},
        '{0, CFG_SEG_SIZE, 0, 8'h7F, 16'h0000, 0, 0, 0, 16'h0000, 0, 0, 0, 0},
        '{0, CFG_SEG_SIZE, 0, 8'hFE, 16'h0000, 0, 1, 0, 16'h0000, 0, 0, 0, 0},
        '{0, CFG_SEG_SIZE, 0, 8'h00, 16'h0000, 1, 0, 0, 16'h0000, 0, 0, 0, 0}
    };

    // ------------------------------------------------------------------
    // Stimulus: reset, directed table, random phases, end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_step_row         row;
        bit                closed;
        t_result           r;
        int                phase;
        int                normal_bytes;
        int                len;
        int                good_pct;
        logic [SIZE_W-1:0] size_pick;

        phase        = 0;
        normal_bytes = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            row = directed[k];
            if (row.is_cfg) begin
                settle();
                cfg_write(row.idx, row.value);
            end else begin
                send_byte(row.d, row.cks, row.last, row.match, closed, r);
                if (row.pin) begin
                    r.chk     = row.p_chk;
                    r.ok      = row.p_ok;
                    r.last    = row.last;
                    r.good    = row.p_good;
                    r.total   = row.p_total;
                    r.dropped = row.p_drop;
                end
                if (closed || row.pin) expected_segments.push_back(r);
            end
        end

        // Each phase starts with the sender paused until every result is back,
        // then rewrites both registers. Packets may be left open across phases,
        // so size and mode changes land mid-segment and mid-packet.
        while (normal_bytes < RANDOM_BYTES || phase < 10) begin
            phase++;
            settle();
            gaps_on = ($urandom_range(0, 4) != 0);
            case (phase)
                3: begin
                    // receiver holds off while two-byte segments pile up: input must stall
                    cfg_write(CFG_SEG_SIZE, 12'd2);
                    cfg_write(CFG_WHOLE, {11'($urandom), 1'b0});
                    hold_asks <= hold_asks + 1;
                    gaps_on = 1'b0;
                    send_packet(64, 100, 1'b1);
                end
                6: begin
                    // size 1 behaves as 2: a long run of two-byte segments in one packet
                    cfg_write(CFG_SEG_SIZE, 12'd1);
                    cfg_write(CFG_WHOLE, {11'($urandom), 1'b0});
                    send_packet(200, 100, 1'b1);
                end
                9: begin
                    // largest size register value: 4096-byte span, only packet end closes
                    cfg_write(CFG_SEG_SIZE, 12'hFFF);
                    cfg_write(CFG_WHOLE, {11'($urandom), 1'b0});
                    send_packet(300, 80, 1'b1);
                end
                default: begin
                    case ($urandom_range(0, 19))
                        0:       size_pick = 12'd0;
                        1:       size_pick = 12'd1;
                        2:       size_pick = 12'd2;
                        3:       size_pick = 12'd2048;
                        4:       size_pick = 12'hFFF;
                        5, 6, 7: size_pick = 12'($urandom_range(3, 8));
                        8, 9:    size_pick = 12'($urandom_range(9, 64));
                        default: size_pick = 12'($urandom_range(2, 40));
                    endcase
                    cfg_write(CFG_SEG_SIZE, size_pick);
                    cfg_write(CFG_WHOLE, {11'($urandom), ($urandom_range(0, 3) == 0)});
                    repeat ($urandom_range(1, 6)) begin
                        case ($urandom_range(0, 19))
                            0:       len = $urandom_range(81, 300);
                            1, 2, 3,
                            4, 5:    len = $urandom_range(13, 80);
                            default: len = $urandom_range(1, 12);
                        endcase
                        case ($urandom_range(0, 2))
                            0:       good_pct = 0;    // noise, mostly dropped packets
                            1:       good_pct = 60;
                            default: good_pct = 95;
                        endcase
                        send_packet(len, good_pct, $urandom_range(0, 5) != 0);
                        normal_bytes += len;
                    end
                end
            endcase
        end

        settle();
        if (mismatches == 0) begin
            $display("segmented_ones_complement_checksum_core: match");
        end else begin
            $display("segmented_ones_complement_checksum_core: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/socc_pkg.sv
rtl/socc_front.sv
rtl/socc_queue.sv
rtl/socc_back.sv
rtl/segmented_ones_complement_checksum_core.sv
tb/tb.sv
